/* rtl/sps_pkg.sv */
// shared types, constants and helpers for the slot power sequencer
// no dependencies; imported by every module of the block
`default_nettype none

package sps_pkg;

  localparam int NUM_SLOTS    = 8;
  localparam int MAX_LEVELS   = 4;
  localparam int REPORT_SLOTS = 8;
  localparam int CNT_W        = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  // item kinds
  localparam logic [1:0] KIND_TICK   = 2'd0;
  localparam logic [1:0] KIND_CYCLE  = 2'd1;
  localparam logic [1:0] KIND_ENABLE = 2'd2;
  localparam logic [1:0] KIND_LEVEL  = 2'd3;

  // slot states
  localparam logic [2:0] ST_PERM_OFF  = 3'd0;
  localparam logic [2:0] ST_PREINIT   = 3'd1;
  localparam logic [2:0] ST_CYCLE_OFF = 3'd2;
  localparam logic [2:0] ST_WAIT      = 3'd3;
  localparam logic [2:0] ST_AT_LEVEL  = 3'd4;

  // configuration register indexes
  localparam logic [2:0] REG_FIRST_SLOT   = 3'd0;
  localparam logic [2:0] REG_SLOTS_IN_USE = 3'd1;
  localparam logic [2:0] REG_DEFAULT_LVL  = 3'd2;
  localparam logic [2:0] REG_LEVEL_COUNT  = 3'd3;
  localparam logic [2:0] REG_ON_POLARITY  = 3'd4;
  localparam logic [2:0] REG_PREINIT_MS   = 3'd5;
  localparam logic [2:0] REG_CYCLE_MS     = 3'd6;
  localparam logic [2:0] REG_SETTLE_MS    = 3'd7;

  typedef struct packed {
    logic [2:0]  ctrl_state;
    logic [31:0] state_since;
    logic        power_enabled;
    logic [1:0]  driven_level;
  } rec_t;

  localparam rec_t REC_RESET = '{
    ctrl_state:    ST_PREINIT,
    state_since:   32'd0,
    power_enabled: 1'b1,
    driven_level:  2'd0
  };

  // command and settings seen by the update unit for the head slot
  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] now;
    logic        enable_flag;
    logic [1:0]  level;
    logic        active;
    logic        hit;
    logic [1:0]  default_level;
    logic [1:0]  level_count;
    logic [15:0] preinit_off_ms;
    logic [15:0] cycle_off_ms;
    logic [15:0] settle_ms;
  } cmd_t;

  // requested level only taken when off or within the level count
  function automatic logic [1:0] apply_level(input logic [1:0] cur,
                                             input logic [1:0] req,
                                             input logic [1:0] level_count);
    logic [1:0] res;
    res = cur;
    if (req == 2'd0 || req <= level_count) begin
      res = req;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

/* rtl/sps_cell.sv */
// one slot record of the rotating ring
// depends on sps_pkg for the record type and its reset value
`default_nettype none

module sps_cell (
  input  wire            clk,
  input  wire            rst_n,
  input  wire            shift,
  input  wire sps_pkg::rec_t rec_in,
  output sps_pkg::rec_t  rec_out
);
  import sps_pkg::*;

  rec_t rec_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rec_r <= REC_RESET;
    end else if (shift) begin
      rec_r <= rec_in;
    end
  end

  assign rec_out = rec_r;

endmodule

`default_nettype wire

/* rtl/sps_update.sv */
// next-record logic for the slot record leaving the head of the ring
// depends on sps_pkg for record, command and level helper
`default_nettype none

module sps_update (
  input  wire sps_pkg::cmd_t cmd,
  input  wire sps_pkg::rec_t rec_in,
  output sps_pkg::rec_t  rec_out
);
  import sps_pkg::*;

  logic [15:0] limit;
  logic [31:0] elapsed;
  logic        expired;

  always_comb begin
    case (rec_in.ctrl_state)
      ST_PREINIT:   limit = cmd.preinit_off_ms;
      ST_CYCLE_OFF: limit = cmd.cycle_off_ms;
      default:      limit = cmd.settle_ms;
    endcase
  end

  // wrapped millisecond arithmetic
  assign elapsed = cmd.now - rec_in.state_since;
  assign expired = elapsed > {16'd0, limit};

  always_comb begin
    rec_out = rec_in;
    unique case (cmd.kind)
      KIND_TICK: begin
        if (cmd.active && expired) begin
          case (rec_in.ctrl_state)
            ST_PREINIT: begin
              rec_out.driven_level = 2'd0;
              rec_out.ctrl_state   = ST_CYCLE_OFF;
              rec_out.state_since  = cmd.now;
            end
            ST_WAIT: begin
              rec_out.ctrl_state  = ST_AT_LEVEL;
              rec_out.state_since = cmd.now;
            end
            ST_CYCLE_OFF: begin
              if (rec_in.power_enabled) begin
                rec_out.driven_level = apply_level(rec_in.driven_level,
                                                   cmd.default_level,
                                                   cmd.level_count);
              end
              rec_out.ctrl_state  = ST_WAIT;
              rec_out.state_since = cmd.now;
            end
            default: begin
            end
          endcase
        end
      end
      KIND_CYCLE: begin
        if (cmd.hit) begin
          rec_out.driven_level = 2'd0;
          rec_out.ctrl_state   = ST_CYCLE_OFF;
          rec_out.state_since  = cmd.now;
        end
      end
      KIND_ENABLE: begin
        if (cmd.hit) begin
          rec_out.power_enabled = cmd.enable_flag;
        end
      end
      KIND_LEVEL: begin
        if (cmd.hit) begin
          rec_out.driven_level = apply_level(rec_in.driven_level, cmd.level,
                                             cmd.level_count);
        end
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/slot_power_sequencer.sv */
// Slot power sequencer.
// Input channel (in_valid/in_stall) carries one word per event: a tick with the
// current millisecond time, or a power-cycle, enable/disable or set-level
// command for one bus slot. Every accepted word produces exactly one result
// word on the output channel (out_valid/out_stall): level-pin drives and the
// stable mask of all slots plus the status of the addressed slot.
// The per-slot records sit in a ring of NUM_SLOTS cells that rotates once per
// word; the record at the head passes through a single update unit each cycle
// of a word's pass unless its final step is held by a stalled output. A new
// word is taken in the same cycle as the previous word's final step; only one
// word is in flight at a time. The result sits in an output register; if the
// receiver stalls, the next word still runs its pass and only its final step
// waits for that register.
// Configuration writes (cfg_valid/cfg_ready) are taken while no word is in
// flight. Synchronous reset puts every slot in pre-init off with timestamp 0,
// power enabled and all pins off, and loads the register defaults.
`default_nettype none

module slot_power_sequencer (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [1:0]  in_kind,
  input  wire  [7:0]  in_slot,
  input  wire  [31:0] in_time_ms,
  input  wire         in_enable_flag,
  input  wire  [1:0]  in_level,
  output logic        out_valid,
  input  wire         out_stall,
  output logic [23:0] out_pin_drive,
  output logic [7:0]  out_stable_mask,
  output logic        out_slot_stable,
  output logic        out_slot_controlled,
  output logic [2:0]  out_slot_state,
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [2:0]  cfg_index,
  input  wire  [15:0] cfg_data
);
  import sps_pkg::*;

  // configuration
  logic [7:0]  first_slot_r;
  logic [3:0]  slots_in_use_r;
  logic [1:0]  default_level_r;
  logic [1:0]  level_count_r;
  logic [2:0]  on_polarity_r;
  logic [15:0] preinit_off_ms_r;
  logic [15:0] cycle_off_ms_r;
  logic [15:0] settle_ms_r;

  // sequencing
  logic             busy_r;
  logic [CNT_W-1:0] cnt_r;
  logic             last_step;
  logic             out_free;
  logic             step_en;
  logic             in_fire;

  // latched word
  logic [1:0]  kind_r;
  logic [7:0]  slot_r;
  logic [31:0] now_r;
  logic        enable_flag_r;
  logic [1:0]  level_r;

  // accumulators
  logic [23:0] pins_r, pins_nxt;
  logic [7:0]  mask_r, mask_nxt;
  logic        hit_r, hit_nxt;
  logic [2:0]  hit_st_r, hit_st_nxt;
  logic [2:0]  s0_st_r, s0_st_nxt;

  logic        ctrl_on;
  logic        dl_too_big;
  logic [7:0]  n_active;
  logic        head_active;
  logic        head_hit;
  logic        s0_controlled;
  logic [2:0]  fin_state;

  cmd_t cmd;
  rec_t chain_q [NUM_SLOTS];
  rec_t chain_d [NUM_SLOTS];
  rec_t upd_rec;

  assign cfg_ready = !busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_slot_r     <= 8'd0;
      slots_in_use_r   <= 4'd8;
      default_level_r  <= 2'd1;
      level_count_r    <= 2'd2;
      on_polarity_r    <= 3'd7;
      preinit_off_ms_r <= 16'd100;
      cycle_off_ms_r   <= 16'd500;
      settle_ms_r      <= 16'd100;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_FIRST_SLOT:   first_slot_r     <= cfg_data[7:0];
        REG_SLOTS_IN_USE: slots_in_use_r   <= cfg_data[3:0];
        REG_DEFAULT_LVL:  default_level_r  <= cfg_data[1:0];
        REG_LEVEL_COUNT:  level_count_r    <= cfg_data[1:0];
        REG_ON_POLARITY:  on_polarity_r    <= cfg_data[2:0];
        REG_PREINIT_MS:   preinit_off_ms_r <= cfg_data;
        REG_CYCLE_MS:     cycle_off_ms_r   <= cfg_data;
        REG_SETTLE_MS:    settle_ms_r      <= cfg_data;
      endcase
    end
  end

  // number of controlled slots
  assign ctrl_on    = (slots_in_use_r != 4'd0) &&
                      ((32'(level_count_r) + 32'd1) < 32'(MAX_LEVELS));
  assign dl_too_big = 32'(default_level_r) >= 32'(MAX_LEVELS);

  always_comb begin
    if (!ctrl_on || dl_too_big) begin
      n_active = 8'd0;
    end else if (32'(slots_in_use_r) > 32'(NUM_SLOTS)) begin
      n_active = 8'(NUM_SLOTS);
    end else begin
      n_active = 8'(slots_in_use_r);
    end
  end

  assign head_active   = 8'(cnt_r) < n_active;
  assign head_hit      = head_active &&
                         ((9'(first_slot_r) + 9'(cnt_r)) == 9'(slot_r));
  assign s0_controlled = (first_slot_r == 8'd0) && (n_active != 8'd0);

  assign last_step = (32'(cnt_r) == 32'(NUM_SLOTS - 1));
  assign out_free  = !out_valid || !out_stall;
  assign step_en   = busy_r && (!last_step || out_free);
  assign in_stall  = busy_r && !(last_step && step_en);
  assign in_fire   = in_valid && !in_stall;

  assign cmd = '{
    kind:           kind_r,
    now:            now_r,
    enable_flag:    enable_flag_r,
    level:          level_r,
    active:         head_active,
    hit:            head_hit,
    default_level:  default_level_r,
    level_count:    level_count_r,
    preinit_off_ms: preinit_off_ms_r,
    cycle_off_ms:   cycle_off_ms_r,
    settle_ms:      settle_ms_r
  };

  sps_update u_update (
    .cmd     (cmd),
    .rec_in  (chain_q[0]),
    .rec_out (upd_rec)
  );

  // ring: head leaves through the update unit and re-enters at the tail
  for (genvar j = 0; j < NUM_SLOTS; j++) begin : g_ring
    if (j == NUM_SLOTS - 1) begin : g_tail
      assign chain_d[j] = upd_rec;
    end else begin : g_link
      assign chain_d[j] = chain_q[j+1];
    end
    sps_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .shift   (step_en),
      .rec_in  (chain_d[j]),
      .rec_out (chain_q[j])
    );
  end

  // gather this step's contribution to the result
  always_comb begin
    logic [2:0] slice;
    slice      = 3'd0;
    for (int k = 0; k < 3; k++) begin
      if (32'(k) < 32'(level_count_r)) begin
        slice[k] = (32'(upd_rec.driven_level) == 32'(k + 1)) ?
                   on_polarity_r[k] : !on_polarity_r[k];
      end
    end
    pins_nxt   = pins_r;
    mask_nxt   = mask_r;
    for (int j = 0; j < REPORT_SLOTS; j++) begin
      if (j < NUM_SLOTS && 32'(cnt_r) == 32'(j) && head_active) begin
        pins_nxt[3*j +: 3] = slice;
        mask_nxt[j]        = upd_rec.ctrl_state == ST_AT_LEVEL;
      end
    end
    hit_nxt    = hit_r || head_hit;
    hit_st_nxt = head_hit ? upd_rec.ctrl_state : hit_st_r;
    s0_st_nxt  = (cnt_r == '0) ? upd_rec.ctrl_state : s0_st_r;
  end

  // addressed slot, else slot 0 when controlled, else a fixed at-level answer
  always_comb begin
    if (hit_nxt) begin
      fin_state = hit_st_nxt;
    end else if (s0_controlled) begin
      fin_state = s0_st_nxt;
    end else begin
      fin_state = ST_AT_LEVEL;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      cnt_r     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (in_fire) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (step_en) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (last_step) begin
          busy_r <= 1'b0;
        end
      end
      if (step_en && last_step) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      kind_r        <= in_kind;
      slot_r        <= in_slot;
      now_r         <= in_time_ms;
      enable_flag_r <= in_enable_flag;
      level_r       <= in_level;
      pins_r        <= 24'd0;
      mask_r        <= 8'd0;
      hit_r         <= 1'b0;
      hit_st_r      <= ST_AT_LEVEL;
      s0_st_r       <= ST_AT_LEVEL;
    end else if (step_en) begin
      pins_r   <= pins_nxt;
      mask_r   <= mask_nxt;
      hit_r    <= hit_nxt;
      hit_st_r <= hit_st_nxt;
      s0_st_r  <= s0_st_nxt;
    end
    if (step_en && last_step) begin
      out_pin_drive       <= pins_nxt;
      out_stable_mask     <= mask_nxt;
      out_slot_controlled <= hit_nxt;
      out_slot_state      <= fin_state;
      out_slot_stable     <= fin_state == ST_AT_LEVEL;
    end
  end

endmodule

`default_nettype wire
